// ----- rtl/hrl_pkg.sv -----
// ----------------------------------------------------------------------------
// hrl_pkg
// Shared types and constants for the hex record loader: event codes, the
// token format carried from the parser front to the address back end, and
// the reset value of the load base register.
// ----------------------------------------------------------------------------
package hrl_pkg;

  // Event codes reported on the result channel
  localparam logic [1:0] EV_DATA = 2'd0;
  localparam logic [1:0] EV_OK   = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;
  localparam logic [1:0] EV_EOF  = 2'd3;

  // Reset value of the load base register
  localparam logic [15:0] LOAD_BASE_RST = 16'h0248;

  // One parsed event, waiting for its destination address
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } hrl_tok_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } hrl_q_stat_t;

endpackage

// ----- rtl/hrl_front.sv -----
// ----------------------------------------------------------------------------
// hrl_front
// Character parser. Waits for a colon, pairs hex digits into bytes, walks
// the record header, data and checksum, and pushes one token per data byte
// and one per checksum verdict into the event queue.
// ----------------------------------------------------------------------------
module hrl_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_ascii_char,
  input  hrl_pkg::hrl_q_stat_t q_stat,
  output logic            push,
  output hrl_pkg::hrl_tok_t push_tok
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_CHECK  = 2'd3;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] OFS_DIGIT  = 8'h30;
  localparam logic [7:0] OFS_LETTER = 8'h37;
  localparam logic [7:0] TYPE_EOF   = 8'h01;

  logic [1:0] phase_r, phase_nxt;
  logic       sdd_r, sdd_nxt;
  logic [3:0] high_nib_r, high_nib_nxt;
  logic [1:0] hdr_idx_r, hdr_idx_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] rec_kind_r, rec_kind_nxt;
  logic       done_r, done_nxt;

  logic       accept;
  logic [7:0] diff;
  logic [3:0] nib;
  logic [7:0] pair;
  logic [7:0] sum_add;

  // Take a character whenever the queue has room
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Decode one digit: subtract the digit or letter offset, keep four bits
  assign diff    = (in_ascii_char < CHAR_UPPER) ? (in_ascii_char - OFS_DIGIT)
                                                : (in_ascii_char - OFS_LETTER);
  assign nib     = diff[3:0];
  assign pair    = {high_nib_r, nib};
  assign sum_add = sum_r + pair;

  // Advance the record parser
  always_comb begin
    phase_nxt    = phase_r;
    sdd_nxt      = sdd_r;
    high_nib_nxt = high_nib_r;
    hdr_idx_nxt  = hdr_idx_r;
    left_nxt     = left_r;
    sum_nxt      = sum_r;
    rec_kind_nxt = rec_kind_r;
    done_nxt     = done_r;
    push         = 1'b0;
    push_tok     = '{kind: hrl_pkg::EV_DATA, data: 8'h00};
    if (accept && !done_r) begin
      if (phase_r == PH_IDLE) begin
        if (in_ascii_char == CHAR_COLON) begin
          phase_nxt    = PH_HEADER;
          hdr_idx_nxt  = 2'd0;
          sdd_nxt      = 1'b0;
          sum_nxt      = 8'h00;
          left_nxt     = 8'h00;
          rec_kind_nxt = 8'h00;
        end
      end else if (!sdd_r) begin
        high_nib_nxt = nib;
        sdd_nxt      = 1'b1;
      end else begin
        sdd_nxt = 1'b0;
        unique case (phase_r)
          PH_HEADER: begin
            sum_nxt     = sum_add;
            hdr_idx_nxt = hdr_idx_r + 2'd1;
            if (hdr_idx_r == 2'd0) begin
              left_nxt = pair;
            end else if (hdr_idx_r == 2'd3) begin
              rec_kind_nxt = pair;
              phase_nxt    = (left_r != 8'h00) ? PH_DATA : PH_CHECK;
            end
          end
          PH_DATA: begin
            sum_nxt  = sum_add;
            left_nxt = left_r - 8'd1;
            if (left_r == 8'd1) begin
              phase_nxt = PH_CHECK;
            end
            push     = 1'b1;
            push_tok = '{kind: hrl_pkg::EV_DATA, data: pair};
          end
          PH_CHECK: begin
            // Sum of all bytes including the checksum is zero when correct
            phase_nxt = PH_IDLE;
            push      = 1'b1;
            if (sum_add == 8'h00) begin
              if (rec_kind_r == TYPE_EOF) begin
                done_nxt = 1'b1;
                push_tok = '{kind: hrl_pkg::EV_EOF, data: 8'h00};
              end else begin
                push_tok = '{kind: hrl_pkg::EV_OK, data: 8'h00};
              end
            end else begin
              push_tok = '{kind: hrl_pkg::EV_ERR, data: 8'h00};
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      sdd_r      <= 1'b0;
      high_nib_r <= 4'h0;
      hdr_idx_r  <= 2'd0;
      left_r     <= 8'h00;
      sum_r      <= 8'h00;
      rec_kind_r <= 8'h00;
      done_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      sdd_r      <= sdd_nxt;
      high_nib_r <= high_nib_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      left_r     <= left_nxt;
      sum_r      <= sum_nxt;
      rec_kind_r <= rec_kind_nxt;
      done_r     <= done_nxt;
    end
  end

endmodule

// ----- rtl/hrl_queue.sv -----
// ----------------------------------------------------------------------------
// hrl_queue
// Two-entry event queue between the parser front and the address back end.
// ----------------------------------------------------------------------------
module hrl_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  hrl_pkg::hrl_tok_t     push_tok,
  input  logic                  pop,
  output hrl_pkg::hrl_tok_t     pop_tok,
  output hrl_pkg::hrl_q_stat_t  q_stat
);

  hrl_pkg::hrl_tok_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_tok      = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed token
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ----- rtl/hrl_back.sv -----
// ----------------------------------------------------------------------------
// hrl_back
// Address back end. Pops parsed events, attaches load_base plus the running
// write count (zero on an error) and holds the result in the output register.
// ----------------------------------------------------------------------------
module hrl_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  input  hrl_pkg::hrl_q_stat_t  q_stat,
  input  hrl_pkg::hrl_tok_t     pop_tok,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_event_kind,
  output logic [7:0]            out_data_byte,
  output logic [15:0]           out_dest_address
);

  logic [15:0] base_r;
  logic [15:0] wcnt_r, wcnt_nxt;
  logic        valid_r, valid_nxt;
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] cur_addr;

  // Refill the output register when it is empty or being taken
  assign pop      = !q_stat.empty && (!valid_r || out_ready);
  assign cur_addr = base_r + wcnt_r;

  always_comb begin
    wcnt_nxt  = wcnt_r;
    addr_nxt  = cur_addr;
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (pop) begin
      valid_nxt = 1'b1;
      unique case (pop_tok.kind)
        hrl_pkg::EV_DATA: begin
          wcnt_nxt = wcnt_r + 16'd1;
        end
        hrl_pkg::EV_ERR: begin
          // Rewind to the start of the load area
          wcnt_nxt = 16'h0000;
          addr_nxt = base_r;
        end
        default: begin
          addr_nxt = cur_addr;
        end
      endcase
    end
  end

  // Hold config and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= hrl_pkg::LOAD_BASE_RST;
      wcnt_r  <= 16'h0000;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      wcnt_r  <= wcnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= pop_tok.kind;
      byte_r <= pop_tok.data;
      addr_r <= addr_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_event_kind   = kind_r;
  assign out_data_byte    = byte_r;
  assign out_dest_address = addr_r;

endmodule

// ----- rtl/hex_record_loader_unit.sv -----
// ----------------------------------------------------------------------------
// hex_record_loader_unit
// Intel HEX record loader: parses hex text and reports data bytes with
// their destination addresses plus one verdict per record.
// ----------------------------------------------------------------------------
// Input channel: one ASCII character per transfer on in_ascii_char.
// Result channel: out_event_kind (data, record ok, checksum error, end of
// file), out_data_byte and out_dest_address.
// Configuration: cfg_we writes cfg_wdata into load_base; write only while
// no transfer is outstanding.
// Throughput: one character per cycle while the queue has room; the parser
// front updates once per character and the address back end retires one
// event per cycle while the receiver takes results. A result passes through
// the event queue and then the output register before it reaches out_valid.
// When the receiver stalls, the output register holds its result and the
// two-entry event queue absorbs further events; in_ready drops only when the
// queue is full. After an end of file record, characters are taken and
// dropped until reset. Reset returns the parser to idle, clears the write
// count and sets load_base to 0x0248.
// ----------------------------------------------------------------------------
module hex_record_loader_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ascii_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_dest_address,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  hrl_pkg::hrl_q_stat_t q_stat;
  hrl_pkg::hrl_tok_t    push_tok;
  hrl_pkg::hrl_tok_t    pop_tok;
  logic                 push;
  logic                 pop;

  hrl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_ascii_char (in_ascii_char),
    .q_stat        (q_stat),
    .push          (push),
    .push_tok      (push_tok)
  );

  hrl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .pop_tok  (pop_tok),
    .q_stat   (q_stat)
  );

  hrl_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .q_stat           (q_stat),
    .pop_tok          (pop_tok),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_data_byte    (out_data_byte),
    .out_dest_address (out_dest_address)
  );

endmodule

// ----- rtl/hrl_checker.sv -----
// ----------------------------------------------------------------------------
// hrl_checker
// Port-level checks for the hex record loader, bound to the top level.
// ----------------------------------------------------------------------------
module hrl_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_event_kind,
  input  logic [7:0]  out_data_byte,
  input  logic [15:0] out_dest_address
);

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Verdict events carry a zero data byte
  a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind != hrl_pkg::EV_DATA) |-> (out_data_byte == 8'h00))
    else $error("verdict event with nonzero data byte");

  // No result directly follows a taken end of file event
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_event_kind == hrl_pkg::EV_EOF) |=> !out_valid)
    else $error("result after end of file");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_event_kind) && $stable(out_data_byte)
       && $stable(out_dest_address)))
    else $error("stalled result changed");

endmodule

bind hex_record_loader_unit hrl_checker u_hrl_checker (.*);

// ----- test/hex_record_loader_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_loader_unit_tb
// Feeds Intel HEX text into the loader one character per transfer and checks
// every data byte, record verdict and end of file event against an in-bench
// parser model. A directed set covers digit case, non-hex and colon
// characters inside a record, zero length, odd record types and checksum
// errors. Random records follow under several sender and receiver idling
// mixes, with a long receiver hold-off. A closing end of file record is
// followed by input that must be dropped.
// ----------------------------------------------------------------------------
class hex_load_scoreboard;

  typedef enum logic [1:0] {SEEK_COLON, IN_HEADER, IN_DATA, AT_CHECKSUM} parse_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] addr;
  } load_event_t;

  localparam logic [7:0] COLON    = 8'h3A;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] DIGIT_LO = 8'h30;
  localparam logic [7:0] ALPHA_LO = 8'h37;
  localparam logic [7:0] ALPHA_A  = 8'h41;

  load_event_t  pending_events[$];
  int unsigned  failures;

  logic [15:0]  base;
  parse_phase_t phase;
  bit           second_due;
  logic [3:0]   hi_nib;
  logic [1:0]   hdr_idx;
  logic [7:0]   remaining;
  logic [7:0]   sum;
  logic [7:0]   rec_type;
  logic [15:0]  count;
  bit           file_done;

  function new();
    failures   = 0;
    base       = hrl_pkg::LOAD_BASE_RST;
    phase      = SEEK_COLON;
    second_due = 0;
    hi_nib     = '0;
    hdr_idx    = '0;
    remaining  = '0;
    sum        = '0;
    rec_type   = '0;
    count      = '0;
    file_done  = 0;
  endfunction

  function void set_base(input logic [15:0] value);
    base = value;
  endfunction

  function void push_event(input logic [1:0] kind, input logic [7:0] data,
                           input logic [15:0] addr);
    load_event_t ev;
    ev.kind = kind;
    ev.data = data;
    ev.addr = addr;
    pending_events.push_back(ev);
  endfunction

  // Advance the parser by one accepted character
  function void note_char(input logic [7:0] c);
    logic [7:0] diff;
    logic [3:0] nib;
    logic [7:0] byt;
    logic [7:0] want;
    if (file_done) return;
    if (phase == SEEK_COLON) begin
      if (c == COLON) begin
        phase      = IN_HEADER;
        hdr_idx    = '0;
        second_due = 0;
        sum        = '0;
        remaining  = '0;
        rec_type   = '0;
      end
      return;
    end
    diff = (c < ALPHA_A) ? c - DIGIT_LO : c - ALPHA_LO;
    nib  = diff[3:0];
    if (!second_due) begin
      hi_nib     = nib;
      second_due = 1;
      return;
    end
    second_due = 0;
    byt = {hi_nib, nib};
    case (phase)
      IN_HEADER: begin
        sum = sum + byt;
        if (hdr_idx == 2'd0) begin
          remaining = byt;
        end else if (hdr_idx == 2'd3) begin
          rec_type = byt;
          phase    = (remaining != 0) ? IN_DATA : AT_CHECKSUM;
        end
        hdr_idx = hdr_idx + 2'd1;
      end
      IN_DATA: begin
        push_event(hrl_pkg::EV_DATA, byt, base + count);
        sum       = sum + byt;
        count     = count + 16'd1;
        remaining = remaining - 8'd1;
        if (remaining == 0) phase = AT_CHECKSUM;
      end
      AT_CHECKSUM: begin
        want  = 8'h00 - sum;
        phase = SEEK_COLON;
        if (want == byt) begin
          if (rec_type == REC_EOF) begin
            file_done = 1;
            push_event(hrl_pkg::EV_EOF, 8'h00, base + count);
          end else begin
            push_event(hrl_pkg::EV_OK, 8'h00, base + count);
          end
        end else begin
          // rewind the write pointer on a bad checksum
          count = '0;
          push_event(hrl_pkg::EV_ERR, 8'h00, base);
        end
      end
      default: phase = SEEK_COLON;
    endcase
  endfunction

  // Compare one result transfer against the oldest expected event
  function void check_event(input logic [1:0] kind, input logic [7:0] data,
                            input logic [15:0] addr);
    load_event_t ev;
    if (pending_events.size() == 0) begin
      $error("unexpected result: event_kind %0d data_byte %h dest_address %h",
             kind, data, addr);
      failures++;
      return;
    end
    ev = pending_events.pop_front();
    if (kind !== ev.kind) begin
      $error("event_kind: expected %0d, got %0d", ev.kind, kind);
      failures++;
    end
    if (data !== ev.data) begin
      $error("data_byte: expected %h, got %h", ev.data, data);
      failures++;
    end
    if (addr !== ev.addr) begin
      $error("dest_address: expected %h, got %h", ev.addr, addr);
      failures++;
    end
  endfunction

endclass

module hex_record_loader_unit_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_CHARS  = 190;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam logic [7:0]  COLON        = 8'h3A;
  localparam logic [7:0]  REC_DATA     = 8'h00;
  localparam logic [7:0]  REC_EOF      = 8'h01;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ascii_char = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_event_kind;
  logic [7:0]  out_data_byte;
  logic [15:0] out_dest_address;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;

  hex_load_scoreboard load_board;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  hex_record_loader_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ascii_char    (in_ascii_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_data_byte    (out_data_byte),
    .out_dest_address (out_dest_address),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stall the receiver at random, or hold it off for a long stretch
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      load_board.check_event(out_event_kind, out_data_byte, out_dest_address);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hex_record_loader_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return 8'h30 + nib;
    return (lower ? 8'h61 : 8'h41) + nib - 8'd10;
  endfunction

  // Offer one character and hold it until the transfer
  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_ascii_char <= c;
    do @(posedge clk); while (!in_ready);
    load_board.note_char(c);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  // Characters outside a record, never a colon
  task automatic send_noise(input int unsigned n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom);
      if (c == COLON) c = 8'h00;
      send_char(c);
    end
  endtask

  // Send one record; noisy replaces some data or checksum digits with any byte
  task automatic send_record(input int unsigned len, input logic [7:0] rtype,
                             input bit bad_sum, input bit noisy);
    logic [7:0]  rec[$];
    logic [7:0]  sum;
    logic [15:0] addr;
    bit          lower;
    addr  = 16'($urandom);
    lower = $urandom_range(1);
    rec   = {8'(len), addr[15:8], addr[7:0], rtype};
    for (int i = 0; i < len; i++) rec.push_back(8'($urandom));
    sum = 8'h00;
    foreach (rec[i]) sum += rec[i];
    sum = 8'h00 - sum;
    if (bad_sum) sum += 8'($urandom_range(1, 255));
    rec.push_back(sum);
    send_char(COLON);
    foreach (rec[i]) begin
      if (noisy && i >= 4 && $urandom_range(3) == 0) begin
        send_char(8'($urandom));
        send_char(8'($urandom));
      end else begin
        send_char(hex_char(rec[i][7:4], lower));
        send_char(hex_char(rec[i][3:0], lower));
      end
    end
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (load_board.pending_events.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    load_board.set_base(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  rtype;
    logic [15:0] phase_base[4];
    bit          bad_sum;
    bit          noisy;

    load_board = new();
    phase_base = '{16'hFFFE, 16'h0000, 16'($urandom), 16'hFFFF};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ignored characters, then edge-case records at the reset base
    send_char(8'h00);
    send_char(8'hFF);
    send_text("A0");
    send_record(0, REC_DATA, 0, 0);
    send_text(":0212340000ff");
    send_text("ed");
    send_record(1, REC_EOF, 1, 0);
    send_record(1, 8'hFF, 0, 0);
    send_record(3, 8'h04, 1, 0);
    send_record(2, REC_DATA, 0, 0);
    // colon and non-hex bytes taken as digits inside a record
    send_text(":01000000");
    send_char(COLON);
    send_char(8'hFF);
    send_char(8'h00);
    send_char(8'h80);
    send_record(2, REC_EOF, 1, 0);
    wait_drained();

    // Random records under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_base(phase_base[ph]);
      case (ph)
        0: begin send_gap_pct = 0;  stall_pct = 0;  hold_req = 1; end
        1: begin send_gap_pct = 55; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 55; end
        default: begin send_gap_pct = 17; stall_pct = 17; end
      endcase
      sent = 0;
      while (sent < PHASE_CHARS) begin
        if ($urandom_range(9) < 3) send_noise($urandom_range(1, 3));
        len  = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        pick = $urandom_range(99);
        rtype   = (pick < 70) ? REC_DATA : 8'($urandom);
        bad_sum = ($urandom_range(9) == 0);
        noisy   = ($urandom_range(9) == 0);
        // a type one record must never close the file before the end
        if (rtype == REC_EOF) begin
          bad_sum = 1;
          noisy   = 0;
        end
        send_record(len, rtype, bad_sum, noisy);
        sent += 2 * (len + 5) + 1;
      end
    end

    // Close the file; everything after it must be dropped
    wait_drained();
    send_gap_pct = 0;
    stall_pct    = 0;
    write_base(16'($urandom));
    send_record(2, REC_EOF, 0, 0);
    send_noise(4);
    send_record(3, REC_DATA, 0, 0);
    wait_drained();

    if (load_board.failures == 0 && load_board.pending_events.size() == 0) begin
      $display("hex_record_loader_unit: match");
    end else begin
      $display("hex_record_loader_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- hex_record_loader_unit.f -----
rtl/hrl_pkg.sv
rtl/hrl_front.sv
rtl/hrl_queue.sv
rtl/hrl_back.sv
rtl/hex_record_loader_unit.sv
rtl/hrl_checker.sv
test/hex_record_loader_unit_tb.sv
